// ===== rtl/core/trcl_pkg.sv =====
package trcl_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] OUT_TIMEOUT     = 2'd0;
    localparam logic [1:0] OUT_TIME_EXCEED = 2'd1;
    localparam logic [1:0] OUT_PORT_UNR    = 2'd2;
    localparam logic [1:0] OUT_OTHER_UNR   = 2'd3;

    localparam logic [1:0] REG_SOURCE_PORT    = 2'd0;
    localparam logic [1:0] REG_DEST_PORT_BASE = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS  = 2'd2;

    localparam logic [15:0] SOURCE_PORT_RST    = 16'd0;
    localparam logic [15:0] DEST_PORT_BASE_RST = 16'd33434;
    localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd3;

    localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
    localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
    localparam logic [7:0] TYPE_DEST_UNREACH  = 8'd3;
    localparam logic [7:0] CODE_PORT_UNREACH  = 8'd3;
    localparam logic [7:0] PROTO_UDP          = 8'd17;

    localparam logic [6:0] ICMP_HDR_BYTES   = 7'd8;
    localparam logic [6:0] MIN_IP_HDR_BYTES = 7'd20;
    localparam logic [7:0] PORT_BYTES       = 8'd4;

    localparam logic [15:0] POS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] unreach_code;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_push_t;

endpackage

// ===== rtl/core/trcl_front.sv =====
module trcl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  logic [1:0]            action,
    input  logic [15:0]           seq,
    input  logic [7:0]            packet_byte,
    input  logic                  last_byte,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output trcl_pkg::result_push_t res
);
    import trcl_pkg::*;

    logic [15:0] source_port_reg, dest_port_base_reg, timeout_ticks_reg;
    logic        waiting_reg, waiting_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [15:0] probe_reg, probe_next;
    logic [15:0] pos_reg, pos_next;
    logic [5:0]  ohl_reg, ohl_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  code_reg, code_next;
    logic [5:0]  ihl_reg, ihl_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;

    logic [5:0]  cap_ohl, cap_ihl;
    logic [7:0]  cap_type, cap_code, cap_proto;
    logic [15:0] cap_sport, cap_dport, n_pos, tick_inc, dport_exp;
    logic [6:0]  inner_at;
    logic [7:0]  ports_at;
    logic        texc, unr, hit;
    result_t     hit_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_port_reg    <= SOURCE_PORT_RST;
            dest_port_base_reg <= DEST_PORT_BASE_RST;
            timeout_ticks_reg  <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SOURCE_PORT:    source_port_reg    <= cfg_data;
                REG_DEST_PORT_BASE: dest_port_base_reg <= cfg_data;
                REG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // capture the current byte at its offset
    always_comb
    begin
        cap_ohl   = (pos_reg == 16'd0) ? {packet_byte[3:0], 2'b00} : ohl_reg;
        inner_at  = {1'b0, cap_ohl} + ICMP_HDR_BYTES;
        cap_type  = (pos_reg == {10'd0, cap_ohl}) ? packet_byte : type_reg;
        cap_code  = (pos_reg == {9'd0, {1'b0, cap_ohl} + 7'd1}) ? packet_byte : code_reg;
        cap_ihl   = (pos_reg == {9'd0, inner_at}) ? {packet_byte[3:0], 2'b00} : ihl_reg;
        cap_proto = (pos_reg == {8'd0, {1'b0, inner_at} + 8'd9}) ? packet_byte : proto_reg;
        ports_at  = {1'b0, inner_at} + {2'b00, cap_ihl};
        cap_sport = sport_reg;
        cap_dport = dport_reg;
        if (pos_reg == {8'd0, ports_at})
            cap_sport[15:8] = packet_byte;
        if (pos_reg == {7'd0, {1'b0, ports_at} + 9'd1})
            cap_sport[7:0] = packet_byte;
        if (pos_reg == {7'd0, {1'b0, ports_at} + 9'd2})
            cap_dport[15:8] = packet_byte;
        if (pos_reg == {7'd0, {1'b0, ports_at} + 9'd3})
            cap_dport[7:0] = packet_byte;
        n_pos     = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
        dport_exp = dest_port_base_reg + probe_reg;
        tick_inc  = (ticks_reg == POS_MAX) ? ticks_reg : ticks_reg + 16'd1;
    end

    // classify at packet end
    always_comb
    begin
        texc = (cap_type == TYPE_TIME_EXCEEDED) && (cap_code == CODE_IN_TRANSIT);
        unr  = (cap_type == TYPE_DEST_UNREACH);
        hit  = (n_pos >= {9'd0, {1'b0, cap_ohl} + ICMP_HDR_BYTES})
            && (texc || unr)
            && (n_pos >= {9'd0, {1'b0, cap_ohl} + ICMP_HDR_BYTES + MIN_IP_HDR_BYTES})
            && (n_pos >= {8'd0, {1'b0, inner_at} + {2'b00, cap_ihl} + PORT_BYTES})
            && (cap_proto == PROTO_UDP)
            && (cap_sport == source_port_reg)
            && (cap_dport == dport_exp);
        hit_data.unreach_code = 8'd0;
        if (texc)
            hit_data.outcome = OUT_TIME_EXCEED;
        else if (cap_code == CODE_PORT_UNREACH)
            hit_data.outcome = OUT_PORT_UNR;
        else
        begin
            hit_data.outcome      = OUT_OTHER_UNR;
            hit_data.unreach_code = cap_code;
        end
    end

    always_comb
    begin
        waiting_next = waiting_reg;
        ticks_next   = ticks_reg;
        probe_next   = probe_reg;
        pos_next     = pos_reg;
        ohl_next     = ohl_reg;
        type_next    = type_reg;
        code_next    = code_reg;
        ihl_next     = ihl_reg;
        proto_next   = proto_reg;
        sport_next   = sport_reg;
        dport_next   = dport_reg;
        res.valid             = 1'b0;
        res.data.outcome      = OUT_TIMEOUT;
        res.data.unreach_code = 8'd0;
        if (item_valid)
        begin
            unique case (action)
                ACT_START:
                begin
                    waiting_next = 1'b1;
                    ticks_next   = 16'd0;
                    probe_next   = seq;
                end
                ACT_BYTE:
                begin
                    if (last_byte)
                    begin
                        pos_next   = 16'd0;
                        ohl_next   = 6'd0;
                        type_next  = 8'd0;
                        code_next  = 8'd0;
                        ihl_next   = 6'd0;
                        proto_next = 8'd0;
                        sport_next = 16'd0;
                        dport_next = 16'd0;
                        if (hit && waiting_reg)
                        begin
                            waiting_next = 1'b0;
                            res.valid    = 1'b1;
                            res.data     = hit_data;
                        end
                    end
                    else
                    begin
                        pos_next   = n_pos;
                        ohl_next   = cap_ohl;
                        type_next  = cap_type;
                        code_next  = cap_code;
                        ihl_next   = cap_ihl;
                        proto_next = cap_proto;
                        sport_next = cap_sport;
                        dport_next = cap_dport;
                    end
                end
                ACT_TICK:
                begin
                    if (waiting_reg)
                    begin
                        ticks_next = tick_inc;
                        if (tick_inc >= timeout_ticks_reg)
                        begin
                            waiting_next = 1'b0;
                            res.valid    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            ticks_reg   <= 16'd0;
            probe_reg   <= 16'd0;
            pos_reg     <= 16'd0;
            ohl_reg     <= 6'd0;
            type_reg    <= 8'd0;
            code_reg    <= 8'd0;
            ihl_reg     <= 6'd0;
            proto_reg   <= 8'd0;
            sport_reg   <= 16'd0;
            dport_reg   <= 16'd0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            ticks_reg   <= ticks_next;
            probe_reg   <= probe_next;
            pos_reg     <= pos_next;
            ohl_reg     <= ohl_next;
            type_reg    <= type_next;
            code_reg    <= code_next;
            ihl_reg     <= ihl_next;
            proto_reg   <= proto_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
        end
    end

endmodule

// ===== rtl/core/trcl_queue.sv =====
module trcl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  trcl_pkg::result_push_t wr,
    input  logic                   rd,
    output trcl_pkg::result_t      rd_data,
    output logic                   full,
    output logic                   empty
);
    import trcl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    result_t       mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr.valid && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        if (do_wr && !do_rd)
            count_next = count_reg + CW'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/traceroute_icmp_reply_classifier_unit.sv =====
// A result from the front is written into the result queue; outcome/unreach_code show its head.
// Throughput: one item per cycle while full is low; the front parses each packet byte as it is accepted.
// full rises only when the result queue holds QUEUE_DEPTH items that are not popped.
// Reset (rst_n low, asynchronous): probe idle, packet parse cleared, queue empty,
// registers back to source port 0, base port 33434, timeout 3 ticks.
module traceroute_icmp_reply_classifier_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  action,
    input  logic [15:0] seq,
    input  logic [7:0]  packet_byte,
    input  logic        last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  outcome,
    output logic [7:0]  unreach_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import trcl_pkg::*;

    result_push_t res;
    result_t      head;
    logic         accept;

    assign cfg_ready    = 1'b1;
    assign accept       = push && !full;
    assign outcome      = head.outcome;
    assign unreach_code = head.unreach_code;

    trcl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (accept),
        .action      (action),
        .seq         (seq),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .res         (res)
    );

    trcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res),
        .rd      (pop),
        .rd_data (head),
        .full    (full),
        .empty   (empty)
    );

    a_res_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> accept)
        else $error("result without accepted item");

    a_res_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (action == ACT_TICK) || ((action == ACT_BYTE) && last_byte))
        else $error("result from item that cannot end a probe");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (outcome != OUT_OTHER_UNR)) |-> (unreach_code == 8'd0))
        else $error("nonzero code outside other unreachable");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import trcl_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int FULL_HOLD_CYCLES = 80;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] seq;
        logic [7:0]  data;
        logic        last;
    } classifier_input_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = ACT_TICK;
    logic [15:0] seq = '0;
    logic [7:0]  packet_byte = '0;
    logic        last_byte = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  outcome;
    logic [7:0]  unreach_code;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_SOURCE_PORT;
    logic [15:0] cfg_data = '0;

    classifier_input_t pending_inputs[$];
    result_t           expected_replies[$];

    // predictor state
    logic        probe_open = 1'b0;
    logic [15:0] tick_count = '0;
    logic [15:0] probe_seq = '0;
    logic [15:0] byte_pos = '0;
    logic [5:0]  outer_len = '0;
    logic [5:0]  inner_len = '0;
    logic [7:0]  pkt_type = '0;
    logic [7:0]  pkt_code = '0;
    logic [7:0]  inner_proto = '0;
    logic [15:0] quoted_src = '0;
    logic [15:0] quoted_dst = '0;
    logic [15:0] src_port_reg = SOURCE_PORT_RST;
    logic [15:0] base_port_reg = DEST_PORT_BASE_RST;
    logic [15:0] timeout_reg = TIMEOUT_TICKS_RST;

    // stimulus view of the registers
    logic [15:0] plan_src = SOURCE_PORT_RST;
    logic [15:0] plan_base = DEST_PORT_BASE_RST;
    int          plan_timeout = int'(TIMEOUT_TICKS_RST);

    int fault_count = 0;
    int idle_cycles = 0;
    int items_planned = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_mode = 0;
    int pattern_left = 0;
    int hold_left = 0;
    logic hold_request = 1'b0;

    logic              moved;
    result_t           got;
    classifier_input_t accepted;

    traceroute_icmp_reply_classifier_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .action       (action),
        .seq          (seq),
        .packet_byte  (packet_byte),
        .last_byte    (last_byte),
        .empty        (empty),
        .pop          (pop),
        .outcome      (outcome),
        .unreach_code (unreach_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void classify_input(classifier_input_t it);
        int      pos, icmp_at, inner_at, ports_at, n, h1;
        logic    texc, unr, emit;
        result_t res;
        emit = 1'b0;
        res.outcome = OUT_TIMEOUT;
        res.unreach_code = '0;
        case (it.action)
            ACT_START:
            begin
                probe_open = 1'b1;
                tick_count = '0;
                probe_seq = it.seq;
            end
            ACT_BYTE:
            begin
                pos = int'(byte_pos);
                if (pos == 0) outer_len = {it.data[3:0], 2'b00};
                icmp_at = int'(outer_len);
                inner_at = icmp_at + int'(ICMP_HDR_BYTES);
                if (pos == icmp_at) pkt_type = it.data;
                if (pos == icmp_at + 1) pkt_code = it.data;
                if (pos == inner_at) inner_len = {it.data[3:0], 2'b00};
                if (pos == inner_at + 9) inner_proto = it.data;
                ports_at = inner_at + int'(inner_len);
                if (pos == ports_at) quoted_src[15:8] = it.data;
                if (pos == ports_at + 1) quoted_src[7:0] = it.data;
                if (pos == ports_at + 2) quoted_dst[15:8] = it.data;
                if (pos == ports_at + 3) quoted_dst[7:0] = it.data;
                if (byte_pos != POS_MAX) byte_pos++;
                if (it.last)
                begin
                    n = int'(byte_pos);
                    h1 = int'(outer_len);
                    texc = (pkt_type == TYPE_TIME_EXCEEDED) && (pkt_code == CODE_IN_TRANSIT);
                    unr = (pkt_type == TYPE_DEST_UNREACH);
                    emit = probe_open && (texc || unr)
                        && n >= h1 + int'(ICMP_HDR_BYTES) + int'(MIN_IP_HDR_BYTES)
                        && n >= h1 + int'(ICMP_HDR_BYTES) + int'(inner_len)
                                + int'(PORT_BYTES)
                        && inner_proto == PROTO_UDP
                        && quoted_src == src_port_reg
                        && quoted_dst == 16'(base_port_reg + probe_seq);
                    if (texc)
                        res.outcome = OUT_TIME_EXCEED;
                    else if (pkt_code == CODE_PORT_UNREACH)
                        res.outcome = OUT_PORT_UNR;
                    else
                    begin
                        res.outcome = OUT_OTHER_UNR;
                        res.unreach_code = pkt_code;
                    end
                    byte_pos = '0;
                    outer_len = '0;
                    pkt_type = '0;
                    pkt_code = '0;
                    inner_len = '0;
                    inner_proto = '0;
                    quoted_src = '0;
                    quoted_dst = '0;
                end
            end
            ACT_TICK:
            begin
                if (probe_open)
                begin
                    if (tick_count != 16'hFFFF) tick_count++;
                    emit = (tick_count >= timeout_reg);
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            probe_open = 1'b0;
            expected_replies.push_back(res);
        end
    endfunction

    task automatic report_fault(string what, result_t want, result_t seen);
        fault_count++;
        if (fault_count <= 10)
            $display("mismatch (%s): expected outcome %0d code %0d, got outcome %0d code %0d",
                     what, want.outcome, want.unreach_code, seen.outcome, seen.unreach_code);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                case (cfg_index)
                    REG_SOURCE_PORT:    src_port_reg = cfg_data;
                    REG_DEST_PORT_BASE: base_port_reg = cfg_data;
                    REG_TIMEOUT_TICKS:  timeout_reg = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                got.outcome = outcome;
                got.unreach_code = unreach_code;
                if (expected_replies.size() == 0)
                    report_fault("no result expected", got, got);
                else if (got.outcome !== expected_replies[0].outcome
                         || got.unreach_code !== expected_replies[0].unreach_code)
                    report_fault("wrong field", expected_replies.pop_front(), got);
                else
                    void'(expected_replies.pop_front());
            end
            if (push && !full)
            begin
                moved = 1'b1;
                void'(pending_inputs.pop_front());
                accepted.action = action;
                accepted.seq = seq;
                accepted.data = packet_byte;
                accepted.last = last_byte;
                classify_input(accepted);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // sender: bursts with random gaps
    always @(negedge clk)
    begin
        if (!rst_n || pending_inputs.size() == 0)
            push <= 1'b0;
        else if (gap_left > 0)
        begin
            gap_left--;
            push <= 1'b0;
        end
        else
        begin
            push <= 1'b1;
            action <= pending_inputs[0].action;
            seq <= pending_inputs[0].seq;
            packet_byte <= pending_inputs[0].data;
            last_byte <= pending_inputs[0].last;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver: stall pattern, long hold on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = FULL_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                pattern_left = $urandom_range(8, 64);
            end
            pattern_left--;
            case (rx_mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 4) == 0);
                default: pop <= ~pop;
            endcase
        end
    end

    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    function automatic void queue_input(logic [1:0] act, logic [15:0] sq, logic [7:0] b,
                                        logic lst);
        classifier_input_t it;
        it.action = act;
        it.seq = sq;
        it.data = b;
        it.last = lst;
        pending_inputs.push_back(it);
        items_planned++;
    endfunction

    task automatic add_start(logic [15:0] sq);
        queue_input(ACT_START, sq, 8'($urandom), 1'($urandom));
    endtask

    task automatic add_tick();
        queue_input(ACT_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic queue_packet(input logic [7:0] pkt[$]);
        foreach (pkt[i])
            queue_input(ACT_BYTE, 16'($urandom), pkt[i], i == pkt.size() - 1);
    endtask

    task automatic add_reply(int ho, int hi, logic [7:0] typ, logic [7:0] code,
                             logic [7:0] proto, logic [15:0] sp, logic [15:0] dp,
                             int extra, int drop);
        logic [7:0] pkt[$];
        int         h1, p, total;
        h1 = ho * 4;
        p = h1 + 8 + hi * 4;
        total = p + 4 + extra;
        repeat (total) pkt.push_back(8'($urandom));
        pkt[0] = {4'($urandom), ho[3:0]};
        pkt[h1] = typ;
        pkt[h1 + 1] = code;
        pkt[h1 + 8] = {4'h4, hi[3:0]};
        if (h1 + 17 < total) pkt[h1 + 17] = proto;
        pkt[p] = sp[15:8];
        pkt[p + 1] = sp[7:0];
        pkt[p + 2] = dp[15:8];
        pkt[p + 3] = dp[7:0];
        repeat (drop)
            if (pkt.size() > 1) void'(pkt.pop_back());
        queue_packet(pkt);
    endtask

    task automatic add_noise();
        logic [7:0] pkt[$];
        repeat ($urandom_range(1, 48)) pkt.push_back(8'($urandom));
        queue_packet(pkt);
    endtask

    task automatic add_some_reply(logic [15:0] probe);
        int          ho, hi, extra, drop;
        logic [7:0]  typ, code, proto;
        logic [15:0] sp, dp;
        ho = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
        hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
        typ = TYPE_TIME_EXCEEDED;
        code = CODE_IN_TRANSIT;
        proto = PROTO_UDP;
        sp = plan_src;
        dp = plan_base + probe;
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 24) : 0;
        drop = 0;
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3, 4:
            begin
                typ = TYPE_DEST_UNREACH;
                code = CODE_PORT_UNREACH;
            end
            5:
            begin
                typ = TYPE_DEST_UNREACH;
                code = 8'($urandom);
            end
            6: code = 8'($urandom_range(1, 255));
            7: typ = 8'($urandom);
            8:
            begin
                case ($urandom_range(0, 2))
                    0:       proto = 8'($urandom);
                    1:       sp ^= 16'(1 << $urandom_range(0, 15));
                    default: dp ^= 16'(1 << $urandom_range(0, 15));
                endcase
            end
            default: drop = $urandom_range(1, 40);
        endcase
        add_reply(ho, hi, typ, code, proto, sp, dp, extra, drop);
    endtask

    task automatic add_clutter();
        case ($urandom_range(0, 3))
            0:       add_tick();
            1:       queue_input(ACT_UNUSED, 16'($urandom), 8'($urandom), 1'($urandom));
            2:       add_noise();
            default: add_some_reply(16'($urandom));
        endcase
    endtask

    task automatic add_episode();
        logic [15:0] sq;
        sq = 16'($urandom);
        add_start(sq);
        repeat ($urandom_range(0, 3))
        begin
            case ($urandom_range(0, 5))
                0: add_clutter();
                1: add_tick();
                2: add_some_reply(sq + 16'($urandom_range(1, 3)));
                3:
                begin
                    sq = 16'($urandom);
                    add_start(sq);
                end
                default: add_some_reply(sq);
            endcase
        end
        if ($urandom_range(0, 2) == 0 && plan_timeout <= 16)
            repeat ((plan_timeout == 0) ? 1 : plan_timeout) add_tick();
        else
            add_some_reply(sq);
    endtask

    task automatic add_traffic(int n);
        int first;
        first = items_planned;
        while (items_planned - first < n)
        begin
            if ($urandom_range(0, 3) == 0)
                add_clutter();
            else
                add_episode();
        end
    endtask

    task automatic drain_all();
        while (pending_inputs.size() != 0 || expected_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] sp, logic [15:0] base, logic [15:0] ticks);
        write_reg(REG_SOURCE_PORT, sp);
        write_reg(REG_DEST_PORT_BASE, base);
        write_reg(REG_TIMEOUT_TICKS, ticks);
        plan_src = sp;
        plan_base = base;
        plan_timeout = int'(ticks);
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] sq;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_tick();
        queue_input(ACT_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
        add_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP,
                  plan_src, plan_base, 0, 0);
        add_start(16'd0);
        repeat (3) add_tick();
        add_start(16'd5);
        add_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP,
                  plan_src, plan_base + 16'd5, 0, 0);
        add_start(16'hFFFF);
        add_reply(15, 15, TYPE_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP,
                  plan_src, plan_base + 16'hFFFF, 3, 0);
        add_start(16'd1);
        add_reply(5, 5, TYPE_DEST_UNREACH, 8'hFF, PROTO_UDP, plan_src, plan_base + 16'd1, 0, 0);
        add_start(16'd3);
        add_reply(5, 5, TYPE_DEST_UNREACH, 8'h00, PROTO_UDP, plan_src, plan_base + 16'd3, 0, 0);
        add_start(16'd2);
        add_reply(5, 5, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP,
                  plan_src, plan_base + 16'd2, 0, 1);
        add_tick();
        add_start(16'd7);
        add_tick();
        add_tick();
        add_reply(5, 5, TYPE_TIME_EXCEEDED, 8'd1, PROTO_UDP, plan_src, plan_base + 16'd7, 0, 0);
        add_reply(1, 0, TYPE_TIME_EXCEEDED, CODE_IN_TRANSIT, PROTO_UDP,
                  plan_src, plan_base + 16'd7, 16, 0);
        queue_input(ACT_BYTE, 16'h0000, 8'hFF, 1'b1);
        add_tick();
        add_start(16'h8000);
        repeat (3) add_tick();
        drain_all();

        set_config(16'd0, 16'd0, 16'd1);
        add_traffic(80);
        drain_all();

        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        sq = 16'($urandom);
        add_start(sq);
        add_reply(5, 5, TYPE_DEST_UNREACH, CODE_PORT_UNREACH, PROTO_UDP,
                  plan_src, plan_base + sq, 0, 0);
        add_start(16'($urandom));
        repeat (20) add_tick();
        add_traffic(60);
        drain_all();

        set_config(16'($urandom), 16'($urandom), 16'($urandom_range(2, 6)));
        add_traffic(80);
        drain_all();

        set_config(16'($urandom), 16'($urandom), 16'd0);
        add_traffic(60);
        drain_all();

        set_config(16'($urandom), 16'($urandom), 16'd1);
        hold_request = 1'b1;
        repeat (30)
        begin
            add_start(16'($urandom));
            add_tick();
            if ($urandom_range(0, 3) == 0) add_noise();
        end
        drain_all();

        repeat (10) @(negedge clk);
        if (fault_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
